[sv/bpid_pkg.sv]
// Shared types, constants and helpers for the balance PID motor drive core.
// No dependencies; every other file imports this package.
package bpid_pkg;

    // Configuration port geometry
    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;

    // Register indexes, word address = 4 * index
    localparam logic [2:0] REG_GAIN_ANGLE          = 3'd0;
    localparam logic [2:0] REG_GAIN_RATE           = 3'd1;
    localparam logic [2:0] REG_GAIN_ANGLE_INTEGRAL = 3'd2;
    localparam logic [2:0] REG_GAIN_DISTANCE       = 3'd3;
    localparam logic [2:0] REG_GAIN_SPEED          = 3'd4;
    localparam logic [2:0] REG_DEADBAND            = 3'd5;
    localparam logic [2:0] REG_PUNCH_FLOOR         = 3'd6;
    localparam logic [2:0] REG_MOVE_TARGET         = 3'd7;

    // Register reset values
    localparam logic [15:0] RST_GAIN_ANGLE          = 16'd2368;
    localparam logic [15:0] RST_GAIN_RATE           = 16'd54;
    localparam logic [15:0] RST_GAIN_ANGLE_INTEGRAL = 16'd51200;
    localparam logic [15:0] RST_GAIN_DISTANCE       = 16'd5440;
    localparam logic [15:0] RST_GAIN_SPEED          = 16'd173;
    localparam logic [6:0]  RST_DEADBAND            = 7'd10;
    localparam logic [6:0]  RST_PUNCH_FLOOR         = 7'd20;
    localparam logic [15:0] RST_MOVE_TARGET         = 16'd0;

    // Control constants
    localparam int POWER_LIMIT = 127;
    localparam int PUNCH_TICKS = 1;
    localparam int MAG_W       = 7;
    localparam int DRIVE_W     = 8;
    localparam logic [MAG_W-1:0] RUN_MAX = 7'd100;

    // dt/4 scale: x * 41943 / 2^22
    localparam logic [15:0] DT_MUL = 16'd41943;

    // Digit-serial multiplier: signed A times unsigned B, 4-bit digits of B
    localparam int MUL_A_W     = 36;
    localparam int MUL_B_W     = 16;
    localparam int MUL_P_W     = MUL_A_W + MUL_B_W;
    localparam int DIGIT_W     = 4;
    localparam int DIGITS      = MUL_B_W / DIGIT_W;
    localparam int DIGIT_CNT_W = $clog2(DIGITS);

    // Accumulator widths
    localparam int SAT_W = 48;
    localparam int ACC_W = 44;

    typedef struct packed {
        logic [15:0] gain_angle;
        logic [15:0] gain_rate;
        logic [15:0] gain_angle_integral;
        logic [15:0] gain_distance;
        logic [15:0] gain_speed;
        logic [6:0]  deadband;
        logic [6:0]  punch_floor;
        logic [15:0] move_target;
    } cfg_t;

    typedef struct packed {
        logic               start;
        logic [MUL_A_W-1:0] a;
        logic [MUL_B_W-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic               done;
        logic [MUL_P_W-1:0] prod;
    } mul_rsp_t;

    typedef struct packed {
        logic step;
        logic clear;
    } kick_ctl_t;

    typedef struct packed {
        logic [DRIVE_W-1:0] left;
        logic               kick;
    } kick_res_t;

    // Saturate a wide signed value to the 32-bit signed range
    function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
        logic signed [31:0] r;
        if (v[SAT_W-1:31] == {(SAT_W-31){v[31]}}) begin
            r = v[31:0];
        end else if (v[SAT_W-1]) begin
            r = 32'sh8000_0000;
        end else begin
            r = 32'sh7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

[sv/bpid_regs.sv]
// Configuration register file behind an APB-style port.
// Depends on bpid_pkg for the register map, reset values and cfg_t.
module bpid_regs (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [bpid_pkg::ADDR_W-1:0] paddr,
    input  logic [bpid_pkg::DATA_W-1:0] pwdata,
    output logic [bpid_pkg::DATA_W-1:0] prdata,
    output bpid_pkg::cfg_t            cfg
);
    import bpid_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic [2:0] idx;
    logic       wr_en;

    assign idx   = paddr[ADDR_W-1:2];
    assign wr_en = psel & penable & pwrite;
    assign cfg   = cfg_reg;

    // Write decode
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (idx)
                REG_GAIN_ANGLE:          cfg_next.gain_angle          = pwdata[15:0];
                REG_GAIN_RATE:           cfg_next.gain_rate           = pwdata[15:0];
                REG_GAIN_ANGLE_INTEGRAL: cfg_next.gain_angle_integral = pwdata[15:0];
                REG_GAIN_DISTANCE:       cfg_next.gain_distance       = pwdata[15:0];
                REG_GAIN_SPEED:          cfg_next.gain_speed          = pwdata[15:0];
                REG_DEADBAND:            cfg_next.deadband            = pwdata[6:0];
                REG_PUNCH_FLOOR:         cfg_next.punch_floor         = pwdata[6:0];
                REG_MOVE_TARGET:         cfg_next.move_target         = pwdata[15:0];
                default:                 cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gain_angle          <= RST_GAIN_ANGLE;
            cfg_reg.gain_rate           <= RST_GAIN_RATE;
            cfg_reg.gain_angle_integral <= RST_GAIN_ANGLE_INTEGRAL;
            cfg_reg.gain_distance       <= RST_GAIN_DISTANCE;
            cfg_reg.gain_speed          <= RST_GAIN_SPEED;
            cfg_reg.deadband            <= RST_DEADBAND;
            cfg_reg.punch_floor         <= RST_PUNCH_FLOOR;
            cfg_reg.move_target         <= RST_MOVE_TARGET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Read mux; move_target reads back sign-extended
    always_comb
    begin
        case (idx)
            REG_GAIN_ANGLE:          prdata = {16'd0, cfg_reg.gain_angle};
            REG_GAIN_RATE:           prdata = {16'd0, cfg_reg.gain_rate};
            REG_GAIN_ANGLE_INTEGRAL: prdata = {16'd0, cfg_reg.gain_angle_integral};
            REG_GAIN_DISTANCE:       prdata = {16'd0, cfg_reg.gain_distance};
            REG_GAIN_SPEED:          prdata = {16'd0, cfg_reg.gain_speed};
            REG_DEADBAND:            prdata = {25'd0, cfg_reg.deadband};
            REG_PUNCH_FLOOR:         prdata = {25'd0, cfg_reg.punch_floor};
            REG_MOVE_TARGET:         prdata = {{16{cfg_reg.move_target[15]}},
                                               cfg_reg.move_target};
            default:                 prdata = '0;
        endcase
    end

endmodule

[sv/bpid_mul.sv]
// Digit-serial multiplier: signed A times unsigned 16-bit B, one 4-bit digit per cycle.
// Depends on bpid_pkg for widths and the request/response structs.
module bpid_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  bpid_pkg::mul_req_t req,
    output bpid_pkg::mul_rsp_t rsp
);
    import bpid_pkg::*;

    logic signed [MUL_A_W-1:0]         a_reg;
    logic [MUL_B_W-1:0]                b_reg;
    logic [MUL_B_W-1:0]                b_next;
    logic signed [MUL_P_W-1:0]         acc_reg;
    logic signed [MUL_P_W-1:0]         acc_next;
    logic [DIGIT_CNT_W-1:0]            cnt_reg;
    logic [DIGIT_CNT_W-1:0]            cnt_next;
    logic                              busy_reg;
    logic                              busy_next;
    logic                              done_reg;
    logic                              done_next;
    logic signed [MUL_A_W+DIGIT_W:0]   part;

    // Partial product of A and the top digit of B
    assign part = a_reg * $signed({1'b0, b_reg[MUL_B_W-1 -: DIGIT_W]});

    assign rsp.done = done_reg;
    assign rsp.prod = acc_reg;

    // Most significant digit first: acc = acc * 16 + A * digit
    always_comb
    begin
        b_next    = b_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            b_next    = req.b;
            acc_next  = '0;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = (acc_reg <<< DIGIT_W)
                     + {{(MUL_P_W-MUL_A_W-DIGIT_W-1){part[MUL_A_W+DIGIT_W]}}, part};
            b_next   = b_reg << DIGIT_W;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIGIT_CNT_W'(DIGITS-1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Operand and accumulator registers
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            a_reg <= $signed(req.a);
        end
        b_reg   <= b_next;
        acc_reg <= acc_next;
        cnt_reg <= cnt_next;
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

endmodule

[sv/bpid_kick.sv]
// Direction tracker and kick stage: applies punch floor or deadband to the command.
// Depends on bpid_pkg for RUN_MAX, PUNCH_TICKS and the kick structs.
module bpid_kick (
    input  logic                        clk,
    input  logic                        rst_n,
    input  bpid_pkg::kick_ctl_t         ctl,
    input  logic [bpid_pkg::MAG_W-1:0]  cmd_mag,
    input  logic                        cmd_neg,
    input  logic [bpid_pkg::MAG_W-1:0]  deadband,
    input  logic [bpid_pkg::MAG_W-1:0]  punch_floor,
    output bpid_pkg::kick_res_t         res
);
    import bpid_pkg::*;

    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_POS  = 2'd1;
    localparam logic [1:0] DIR_NEG  = 2'd2;
    localparam logic [MAG_W-1:0] PUNCH_CMP = MAG_W'(PUNCH_TICKS);

    logic [1:0]       dir_reg;
    logic [1:0]       dir_next;
    logic [MAG_W-1:0] run_reg;
    logic [MAG_W-1:0] run_next;
    logic [1:0]       want;
    logic [MAG_W-1:0] run_inc;
    logic [MAG_W-1:0] run_new;
    logic             kick;
    logic [MAG_W-1:0] floor_mag;
    logic [MAG_W-1:0] mag_out;

    // Run length in the same direction, saturating
    assign want    = cmd_neg ? DIR_NEG : DIR_POS;
    assign run_inc = (run_reg >= RUN_MAX) ? RUN_MAX : run_reg + 1'b1;
    assign run_new = (dir_reg == want) ? run_inc : '0;

    // Floor selection and magnitude
    assign kick      = (cmd_mag != '0) && (run_new < PUNCH_CMP);
    assign floor_mag = kick ? punch_floor : deadband;
    assign mag_out   = (cmd_mag == '0) ? '0
                     : ((cmd_mag > floor_mag) ? cmd_mag : floor_mag);

    assign res.kick = kick;
    assign res.left = cmd_neg ? (DRIVE_W'(0) - {1'b0, mag_out}) : {1'b0, mag_out};

    // Tracker update
    always_comb
    begin
        dir_next = dir_reg;
        run_next = run_reg;
        if (ctl.clear)
        begin
            dir_next = DIR_NONE;
            run_next = '0;
        end
        else if (ctl.step)
        begin
            if (cmd_mag == '0)
            begin
                dir_next = DIR_NONE;
            end
            else
            begin
                dir_next = want;
                run_next = run_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dir_reg <= DIR_NONE;
            run_reg <= '0;
        end
        else
        begin
            dir_reg <= dir_next;
            run_reg <= run_next;
        end
    end

endmodule

[sv/balance_pid_motor_drive_core.sv]
// Top level of the balance PID motor drive: sequencer, state and output register.
// Depends on bpid_pkg, bpid_regs, bpid_mul and bpid_kick.
//
//   channel   direction  handshake                      payload
//   sample    in         sample_valid / sample_stall    tilt_angle, tilt_rate, clear_state
//   drive     out        drive_valid / drive_stall      left_drive, right_drive, kick_active
//   config    in         APB psel/penable/pwrite        paddr, pwdata, prdata (pready tied)
//
// A control beat runs eight products on the shared 4-bit digit-serial multiplier, then
// forms the command and loads the output register; a clear beat zeroes the state and
// goes straight to the output load.
// Reset zeroes the integrators, power and direction tracker; registers take their defaults.
// A stalled drive beat holds in the output register; a new sample is accepted meanwhile,
// and its result waits for the register to free.
module balance_pid_motor_drive_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bpid_pkg::ADDR_W-1:0]   paddr,
    input  logic [bpid_pkg::DATA_W-1:0]   pwdata,
    output logic [bpid_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    input  logic                          sample_valid,
    output logic                          sample_stall,
    input  logic signed [15:0]            tilt_angle,
    input  logic signed [15:0]            tilt_rate,
    input  logic                          clear_state,
    output logic                          drive_valid,
    input  logic                          drive_stall,
    output logic signed [bpid_pkg::DRIVE_W-1:0] left_drive,
    output logic signed [bpid_pkg::DRIVE_W-1:0] right_drive,
    output logic                          kick_active
);
    import bpid_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE  = 5'b00001,
        ST_ISSUE = 5'b00010,
        ST_MUL   = 5'b00100,
        ST_CMD   = 5'b01000,
        ST_EMIT  = 5'b10000
    } state_t;

    typedef enum logic [2:0] {
        OP_SPEED      = 3'd0,
        OP_DIST_SCALE = 3'd1,
        OP_DIST       = 3'd2,
        OP_ANG_GAIN   = 3'd3,
        OP_ANG_SCALE  = 3'd4,
        OP_SPEED_GAIN = 3'd5,
        OP_ANGLE      = 3'd6,
        OP_RATE       = 3'd7
    } op_t;

    localparam logic signed [31:0] CMD_LIM   = 32'(POWER_LIMIT * 65536);
    localparam logic signed [31:0] CMD_LIM_N = -CMD_LIM;

    cfg_t       cfg;
    mul_req_t   mul_req;
    mul_rsp_t   mul_rsp;
    kick_ctl_t  kick_ctl;
    kick_res_t  kick_res;

    state_t state_reg, state_next;
    op_t    op_reg, op_next;

    logic signed [15:0]        ang_reg, rate_reg;
    logic                      clr_reg, clr_next;
    logic signed [31:0]        si_reg, si_next;
    logic signed [31:0]        dt_reg, dt_next;
    logic signed [31:0]        ai_reg, ai_next;
    logic signed [31:0]        lp_reg, lp_next;
    logic signed [MUL_A_W-1:0] tmp_reg, tmp_next;
    logic signed [ACC_W-1:0]   acc_reg, acc_next;
    logic [MAG_W-1:0]          cmd_mag_reg, cmd_mag_next;
    logic                      cmd_neg_reg, cmd_neg_next;
    logic                      out_valid_reg, out_valid_next;
    logic [DRIVE_W-1:0]        left_reg, right_reg;
    logic                      kick_reg;

    logic                      accept;
    logic                      emit_fire;
    logic signed [29:0]        hi22;
    logic signed [45:0]        lo6;
    logic signed [25:0]        mt1024;
    logic signed [31:0]        dsat;
    logic signed [32:0]        lp_wide;
    logic signed [32:0]        lp_abs;

    assign pready = 1'b1;

    bpid_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    bpid_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .rsp   (mul_rsp)
    );

    bpid_kick u_kick (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (kick_ctl),
        .cmd_mag     (cmd_mag_reg),
        .cmd_neg     (cmd_neg_reg),
        .deadband    (cfg.deadband),
        .punch_floor (cfg.punch_floor),
        .res         (kick_res)
    );

    // Handshakes
    assign sample_stall = (state_reg != ST_IDLE);
    assign accept       = sample_valid & ~sample_stall;
    assign emit_fire    = (state_reg == ST_EMIT) & (~out_valid_reg | ~drive_stall);

    assign kick_ctl.step  = emit_fire & ~clr_reg;
    assign kick_ctl.clear = emit_fire & clr_reg;

    assign drive_valid = out_valid_reg;
    assign left_drive  = left_reg;
    assign right_drive = right_reg;
    assign kick_active = kick_reg;

    // Multiplier start and operand select
    always_comb
    begin
        mul_req.start = (state_reg == ST_ISSUE);
        case (op_reg)
            OP_SPEED:      begin mul_req.a = MUL_A_W'(lp_reg);   mul_req.b = DT_MUL;         end
            OP_DIST_SCALE: begin mul_req.a = MUL_A_W'(si_reg);   mul_req.b = DT_MUL;         end
            OP_DIST:       begin mul_req.a = tmp_reg;            mul_req.b = cfg.gain_distance; end
            OP_ANG_GAIN:   begin mul_req.a = MUL_A_W'(ang_reg);
                                 mul_req.b = cfg.gain_angle_integral;                        end
            OP_ANG_SCALE:  begin mul_req.a = tmp_reg;            mul_req.b = DT_MUL;         end
            OP_SPEED_GAIN: begin mul_req.a = MUL_A_W'(si_reg);   mul_req.b = cfg.gain_speed; end
            OP_ANGLE:      begin mul_req.a = MUL_A_W'(ang_reg);  mul_req.b = cfg.gain_angle; end
            OP_RATE:       begin mul_req.a = MUL_A_W'(rate_reg); mul_req.b = cfg.gain_rate;  end
            default:       begin mul_req.a = '0;                 mul_req.b = '0;             end
        endcase
    end

    // Product slices: floor of /2^22 and /2^6
    assign hi22   = $signed(mul_rsp.prod[MUL_P_W-1:22]);
    assign lo6    = $signed(mul_rsp.prod[MUL_P_W-1:6]);
    assign mt1024 = $signed({cfg.move_target, 10'd0});
    assign dsat   = sat32(SAT_W'(dt_reg) + SAT_W'(lo6));

    // Command magnitude, truncated toward zero
    assign lp_wide = 33'(lp_reg);
    assign lp_abs  = lp_reg[31] ? -lp_wide : lp_wide;

    // Sequencer
    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        clr_next     = clr_reg;
        si_next      = si_reg;
        dt_next      = dt_reg;
        ai_next      = ai_reg;
        lp_next      = lp_reg;
        tmp_next     = tmp_reg;
        acc_next     = acc_reg;
        cmd_mag_next = cmd_mag_reg;
        cmd_neg_next = cmd_neg_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    clr_next = clear_state;
                    op_next  = OP_SPEED;
                    if (clear_state)
                    begin
                        si_next    = '0;
                        dt_next    = '0;
                        ai_next    = '0;
                        lp_next    = '0;
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_ISSUE:
            begin
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                if (mul_rsp.done)
                begin
                    // Fold the finished product into the state
                    case (op_reg)
                        OP_SPEED:      si_next = sat32(SAT_W'(si_reg) + SAT_W'(hi22));
                        OP_DIST_SCALE: tmp_next = MUL_A_W'(hi22) - MUL_A_W'(mt1024);
                        OP_DIST:
                        begin
                            dt_next  = dsat;
                            acc_next = ACC_W'(dsat);
                        end
                        OP_ANG_GAIN:   tmp_next = $signed({mul_rsp.prod[32:0], 3'd0});
                        OP_ANG_SCALE:  ai_next = sat32(SAT_W'(ai_reg) + SAT_W'(hi22));
                        OP_SPEED_GAIN: acc_next = acc_reg + ACC_W'(ai_reg)
                                                + $signed(mul_rsp.prod[ACC_W+5:6]);
                        OP_ANGLE:      acc_next = acc_reg
                                                + $signed({mul_rsp.prod[ACC_W-4:0], 3'd0});
                        OP_RATE:       lp_next = sat32(SAT_W'(acc_reg
                                                + $signed({mul_rsp.prod[ACC_W-6:0], 5'd0})));
                        default:       acc_next = acc_reg;
                    endcase
                    if (op_reg == OP_RATE)
                    begin
                        state_next = ST_CMD;
                    end
                    else
                    begin
                        op_next    = op_t'(op_reg + 3'd1);
                        state_next = ST_ISSUE;
                    end
                end
            end
            ST_CMD:
            begin
                if (lp_reg >= CMD_LIM)
                begin
                    cmd_mag_next = MAG_W'(POWER_LIMIT);
                    cmd_neg_next = 1'b0;
                end
                else if (lp_reg <= CMD_LIM_N)
                begin
                    cmd_mag_next = MAG_W'(POWER_LIMIT);
                    cmd_neg_next = 1'b1;
                end
                else
                begin
                    cmd_mag_next = lp_abs[22:16];
                    cmd_neg_next = lp_reg[31];
                end
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (emit_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Output register valid
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
        end
        else if (!drive_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    // Control and integrator state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            op_reg        <= OP_SPEED;
            clr_reg       <= 1'b0;
            si_reg        <= '0;
            dt_reg        <= '0;
            ai_reg        <= '0;
            lp_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            clr_reg       <= clr_next;
            si_reg        <= si_next;
            dt_reg        <= dt_next;
            ai_reg        <= ai_next;
            lp_reg        <= lp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload and scratch registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ang_reg  <= tilt_angle;
            rate_reg <= tilt_rate;
        end
        tmp_reg     <= tmp_next;
        acc_reg     <= acc_next;
        cmd_mag_reg <= cmd_mag_next;
        cmd_neg_reg <= cmd_neg_next;
        if (emit_fire)
        begin
            if (clr_reg)
            begin
                left_reg  <= '0;
                right_reg <= '0;
                kick_reg  <= 1'b0;
            end
            else
            begin
                left_reg  <= kick_res.left;
                right_reg <= DRIVE_W'(0) - kick_res.left;
                kick_reg  <= kick_res.kick;
            end
        end
    end

    // Checks
    a_kick_drives: assert property (@(posedge clk) disable iff (!rst_n)
        drive_valid |-> !(kick_active && (left_drive == '0)))
        else $error("kick flagged on a zero drive beat");

    a_mirror: assert property (@(posedge clk) disable iff (!rst_n)
        drive_valid |-> (right_drive == -left_drive))
        else $error("right drive is not the negated left drive");

    a_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
        mul_rsp.done |-> (state_reg == ST_MUL))
        else $error("multiplier finished outside the multiply state");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        emit_fire |=> (drive_valid && (state_reg == ST_IDLE)))
        else $error("emitted beat did not reach the output register");

endmodule

[bench/tb.sv]
// Testbench for balance_pid_motor_drive_core: tilt samples in, motor drive beats out.
// Depends on bpid_pkg and the core RTL; a local control-law predictor checks every beat.
// Configuration is loaded over the APB port only while the core is drained.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bpid_pkg::*;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 5;
    localparam int QUIET_LIMIT   = 4000;
    localparam int TAIL_CYCLES   = 120;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_ITEMS  = 570;
    localparam int MAX_PRINTS    = 100;
    localparam int DT_SHIFT      = 22;
    localparam longint DT_K      = longint'(DT_MUL);
    localparam longint S32_MAX   = 64'sd2147483647;
    localparam longint S32_MIN   = -64'sd2147483648;

    // drive direction codes of the kick tracker
    localparam logic [1:0] DIR_NONE = 2'd0;
    localparam logic [1:0] DIR_POS  = 2'd1;
    localparam logic [1:0] DIR_NEG  = 2'd2;

    typedef struct packed {
        logic signed [7:0] left;
        logic signed [7:0] right;
        logic              kick;
    } drive_t;

    // DUT signals; all inputs driven to known values from time zero
    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 psel         = 1'b0;
    logic                 penable      = 1'b0;
    logic                 pwrite       = 1'b0;
    logic [ADDR_W-1:0]    paddr        = '0;
    logic [DATA_W-1:0]    pwdata       = '0;
    logic [DATA_W-1:0]    prdata;
    logic                 pready;
    logic                 sample_valid = 1'b0;
    logic                 sample_stall;
    logic signed [15:0]   tilt_angle   = '0;
    logic signed [15:0]   tilt_rate    = '0;
    logic                 clear_state  = 1'b0;
    logic                 drive_valid;
    logic                 drive_stall  = 1'b0;
    logic signed [DRIVE_W-1:0] left_drive;
    logic signed [DRIVE_W-1:0] right_drive;
    logic                 kick_active;

    // predictor state and register mirror
    cfg_t        cfg_mirror;
    int          last_pwr;
    int          speed_int;
    int          dist_term;
    int          angle_int;
    logic [1:0]  dir_state;
    int          run_cnt;

    drive_t      pending_drive[$];
    int          mismatch_cnt = 0;
    int          quiet_cycles = 0;
    bit          idle_on      = 1'b1;
    int          hold_req     = 0;

    balance_pid_motor_drive_core u_top (.*);

    always #(CLK_HALF) clk = ~clk;

    function automatic int clamp_s32(input longint v);
        if (v > S32_MAX) return int'(S32_MAX);
        if (v < S32_MIN) return int'(S32_MIN);
        return int'(v);
    endfunction

    // x * 0.01, floored
    function automatic longint dt_scale(input longint x);
        return (x * DT_K) >>> DT_SHIFT;
    endfunction

    // one control tick: update integrators, form command, apply kick / deadband
    function automatic drive_t balance_tick(input logic signed [15:0] ang_in,
                                            input logic signed [15:0] rate_in,
                                            input logic clr);
        longint a, r, t, p, lim, cmd, flo, lft, rgt;
        logic [1:0] want;
        drive_t res;
        res = '0;
        if (clr) begin
            last_pwr  = 0;
            speed_int = 0;
            dist_term = 0;
            angle_int = 0;
            dir_state = DIR_NONE;
            run_cnt   = 0;
            return res;
        end
        a = ang_in;
        r = rate_in;
        speed_int = clamp_s32(longint'(speed_int) + dt_scale(longint'(last_pwr)));
        t = dt_scale(longint'(speed_int)) - longint'($signed(cfg_mirror.move_target)) * 1024;
        dist_term = clamp_s32(longint'(dist_term)
                              + ((longint'(cfg_mirror.gain_distance) * t) >>> 6));
        angle_int = clamp_s32(longint'(angle_int)
                              + dt_scale(longint'(cfg_mirror.gain_angle_integral) * a * 8));
        p = longint'(angle_int) + longint'(dist_term)
          + ((longint'(cfg_mirror.gain_speed) * longint'(speed_int)) >>> 6)
          + longint'(cfg_mirror.gain_angle) * a * 8
          + longint'(cfg_mirror.gain_rate) * r * 32;
        last_pwr = clamp_s32(p);

        // clamp to the power limit, truncate toward zero
        lim = longint'(POWER_LIMIT) <<< 16;
        if (longint'(last_pwr) >= lim) cmd = POWER_LIMIT;
        else if (longint'(last_pwr) <= -lim) cmd = -POWER_LIMIT;
        else if (last_pwr >= 0) cmd = longint'(last_pwr) >>> 16;
        else cmd = -((-longint'(last_pwr)) >>> 16);

        if (cmd == 0) begin
            lft = 0;
            dir_state = DIR_NONE;
        end else begin
            want = (cmd > 0) ? DIR_POS : DIR_NEG;
            if (dir_state == want)
                run_cnt = (run_cnt + 1 > int'(RUN_MAX)) ? int'(RUN_MAX) : run_cnt + 1;
            else
                run_cnt = 0;
            dir_state = want;
            if (run_cnt < PUNCH_TICKS) begin
                flo = cfg_mirror.punch_floor;
                res.kick = 1'b1;
            end else begin
                flo = cfg_mirror.deadband;
            end
            if (cmd > 0) lft = (cmd > flo) ? cmd : flo;
            else lft = (cmd < -flo) ? cmd : -flo;
        end
        if (lft > 127) lft = 127;
        if (lft < -127) lft = -127;
        rgt = -lft;
        res.left  = lft[7:0];
        res.right = rgt[7:0];
        return res;
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_cnt++;
        if (mismatch_cnt <= MAX_PRINTS)
            $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    function automatic int pick_gap();
        int roll;
        if (!idle_on) return 0;
        roll = $urandom_range(99);
        if (roll < 65) return 0;
        if (roll < 94) return $urandom_range(3, 1);
        return $urandom_range(60, 10);
    endfunction

    // offer one sample beat, wait for acceptance, queue its predicted drive
    task automatic send_sample(input logic signed [15:0] ang, input logic signed [15:0] rate,
                               input logic clr);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge clk);
            sample_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        sample_valid <= 1'b1;
        tilt_angle   <= ang;
        tilt_rate    <= rate;
        clear_state  <= clr;
        do @(posedge clk); while (sample_stall);
        pending_drive.push_back(balance_tick(ang, rate, clr));
    endtask

    // must follow the last send_sample of a batch without delay
    task automatic end_samples();
        @(negedge clk);
        sample_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_drive.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(negedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_GAIN_ANGLE:          cfg_mirror.gain_angle          = val[15:0];
            REG_GAIN_RATE:           cfg_mirror.gain_rate           = val[15:0];
            REG_GAIN_ANGLE_INTEGRAL: cfg_mirror.gain_angle_integral = val[15:0];
            REG_GAIN_DISTANCE:       cfg_mirror.gain_distance       = val[15:0];
            REG_GAIN_SPEED:          cfg_mirror.gain_speed          = val[15:0];
            REG_DEADBAND:            cfg_mirror.deadband            = val[6:0];
            REG_PUNCH_FLOOR:         cfg_mirror.punch_floor         = val[6:0];
            REG_MOVE_TARGET:         cfg_mirror.move_target         = val[15:0];
            default: ;
        endcase
    endtask

    // write every register; bits above each field carry junk
    task automatic load_config(input cfg_t c);
        reg_write(REG_GAIN_ANGLE,          {16'($urandom()), c.gain_angle});
        reg_write(REG_GAIN_RATE,           {16'($urandom()), c.gain_rate});
        reg_write(REG_GAIN_ANGLE_INTEGRAL, {16'($urandom()), c.gain_angle_integral});
        reg_write(REG_GAIN_DISTANCE,       {16'($urandom()), c.gain_distance});
        reg_write(REG_GAIN_SPEED,          {16'($urandom()), c.gain_speed});
        reg_write(REG_DEADBAND,            {25'($urandom()), c.deadband});
        reg_write(REG_PUNCH_FLOOR,         {25'($urandom()), c.punch_floor});
        reg_write(REG_MOVE_TARGET,         {16'($urandom()), c.move_target});
    endtask

    function automatic cfg_t default_config();
        cfg_t c;
        c.gain_angle          = RST_GAIN_ANGLE;
        c.gain_rate           = RST_GAIN_RATE;
        c.gain_angle_integral = RST_GAIN_ANGLE_INTEGRAL;
        c.gain_distance       = RST_GAIN_DISTANCE;
        c.gain_speed          = RST_GAIN_SPEED;
        c.deadband            = RST_DEADBAND;
        c.punch_floor         = RST_PUNCH_FLOOR;
        c.move_target         = RST_MOVE_TARGET;
        return c;
    endfunction

    function automatic logic [15:0] pick_gain(input logic [15:0] nominal);
        int roll;
        roll = $urandom_range(99);
        if (roll < 10) return 16'd0;
        if (roll < 20) return 16'hFFFF;
        if (roll < 65) return 16'($urandom_range(int'(nominal) * 2));
        return 16'($urandom());
    endfunction

    function automatic logic [6:0] pick_floor();
        int roll;
        roll = $urandom_range(99);
        if (roll < 15) return 7'd0;
        if (roll < 30) return 7'd127;
        return 7'($urandom_range(40));
    endfunction

    function automatic cfg_t random_config();
        cfg_t c;
        int roll;
        c.gain_angle          = pick_gain(RST_GAIN_ANGLE);
        c.gain_rate           = pick_gain(RST_GAIN_RATE);
        c.gain_angle_integral = pick_gain(RST_GAIN_ANGLE_INTEGRAL);
        c.gain_distance       = pick_gain(RST_GAIN_DISTANCE);
        c.gain_speed          = pick_gain(RST_GAIN_SPEED);
        c.deadband            = pick_floor();
        c.punch_floor         = pick_floor();
        roll = $urandom_range(99);
        if (roll < 40) c.move_target = 16'd0;
        else if (roll < 50) c.move_target = 16'h8000;
        else if (roll < 60) c.move_target = 16'h7FFF;
        else if (roll < 80) c.move_target = 16'(int'($urandom_range(600)) - 300);
        else c.move_target = 16'($urandom());
        return c;
    endfunction

    // extremes, kick and deadband, direction change, clear, floors and gain corners
    task automatic test_directed();
        cfg_t c;
        idle_on = 1'b1;
        c = default_config();
        load_config(c);
        send_sample(16'sd0, 16'sd0, 1'b1);
        send_sample(16'sd0, 16'sd0, 1'b0);          // zero command
        send_sample(16'sd64, 16'sd0, 1'b0);         // first tick forward: punch floor
        send_sample(16'sd64, 16'sd0, 1'b0);         // then deadband
        send_sample(16'sd64, 16'sd0, 1'b0);
        send_sample(-16'sd300, 16'sd0, 1'b0);       // direction change
        send_sample(-16'sd300, 16'sd0, 1'b0);
        send_sample(16'sd0, 16'sd0, 1'b1);
        send_sample(16'sd0, 16'sd200, 1'b0);
        send_sample(16'sh7FFF, 16'sh7FFF, 1'b0);
        send_sample(-16'sh8000, -16'sh8000, 1'b0);
        send_sample(-16'sh8000, 16'sh7FFF, 1'b0);
        send_sample(16'sh1234, -16'sh5433, 1'b1);   // clear ignores its payload
        end_samples();
        wait_drained();

        // floors at full scale: small commands are lifted to the output clamp
        c.deadband    = 7'd127;
        c.punch_floor = 7'd127;
        load_config(c);
        send_sample(16'sd8, 16'sd0, 1'b0);
        send_sample(16'sd8, 16'sd0, 1'b0);
        send_sample(-16'sd8, 16'sd0, 1'b0);
        end_samples();
        wait_drained();

        // all gains zero, far target: no power at all
        c = '0;
        c.move_target = 16'h7FFF;
        load_config(c);
        send_sample(16'sh7FFF, -16'sh8000, 1'b0);
        send_sample(-16'sd5, 16'sd77, 1'b0);
        end_samples();
        wait_drained();

        // all gains full scale, most negative target
        c.gain_angle          = 16'hFFFF;
        c.gain_rate           = 16'hFFFF;
        c.gain_angle_integral = 16'hFFFF;
        c.gain_distance       = 16'hFFFF;
        c.gain_speed          = 16'hFFFF;
        c.deadband            = 7'd0;
        c.punch_floor         = 7'd0;
        c.move_target         = 16'h8000;
        load_config(c);
        send_sample(16'sd0, 16'sd0, 1'b1);
        send_sample(16'sd1, -16'sd1, 1'b0);
        send_sample(-16'sh8000, 16'sh7FFF, 1'b0);
        send_sample(16'sh7FFF, 16'sh7FFF, 1'b0);
        end_samples();
        wait_drained();
    endtask

    // receiver holds off for a long stretch while beats keep coming
    task automatic test_output_backpressure();
        load_config(default_config());
        idle_on  = 1'b0;
        hold_req = HOLD_CYCLES;
        send_sample(16'sd0, 16'sd0, 1'b1);
        repeat (8) send_sample(16'(int'($urandom_range(400)) - 200),
                               16'(int'($urandom_range(800)) - 400), 1'b0);
        end_samples();
        idle_on = 1'b1;
        wait_drained();
    endtask

    // balance episodes with drifting tilt, plus noise, under changing settings
    task automatic test_random_episodes();
        int sent, ticks, ang, rate, episode;
        sent    = 0;
        episode = 0;
        while (sent < RANDOM_ITEMS) begin
            if (episode % 5 == 4) begin
                end_samples();
                wait_drained();
                load_config(random_config());
            end
            idle_on = ($urandom_range(99) >= 20);
            if ($urandom_range(99) < 75) begin
                send_sample(16'($urandom()), 16'($urandom()), 1'b1);
                ang   = int'($urandom_range(800)) - 400;
                ticks = $urandom_range(40, 5);
                repeat (ticks) begin
                    ang += int'($urandom_range(128)) - 64;
                    if (ang > 2000) ang = 2000;
                    if (ang < -2000) ang = -2000;
                    rate = int'($urandom_range(3000)) - 1500;
                    send_sample(ang[15:0], rate[15:0], 1'b0);
                end
                sent += ticks + 1;
            end else begin
                ticks = $urandom_range(15, 3);
                repeat (ticks)
                    send_sample(16'($urandom()), 16'($urandom()), $urandom_range(7) == 0);
                sent += ticks;
            end
            episode++;
        end
        end_samples();
        idle_on = 1'b1;
    endtask

    // drive-side stall pattern, long hold on request
    initial begin
        int run_len;
        int roll;
        logic lvl;
        int hold_left;
        run_len   = 0;
        lvl       = 1'b0;
        hold_left = 0;
        forever begin
            @(negedge clk);
            if (hold_req > 0) begin
                hold_left = hold_req;
                hold_req  = 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                drive_stall <= 1'b1;
            end else if (!idle_on) begin
                run_len = 0;
                drive_stall <= 1'b0;
            end else begin
                if (run_len == 0) begin
                    if ($urandom_range(99) < 70) begin
                        lvl     = 1'b0;
                        run_len = $urandom_range(20, 1);
                    end else begin
                        lvl  = 1'b1;
                        roll = $urandom_range(99);
                        if (roll < 80) run_len = $urandom_range(3, 1);
                        else if (roll < 95) run_len = $urandom_range(12, 4);
                        else run_len = $urandom_range(80, 20);
                    end
                end
                run_len--;
                drive_stall <= lvl;
            end
        end
    end

    // compare each drive beat with the oldest prediction
    always @(posedge clk) begin
        drive_t want;
        if (rst_n && drive_valid && !drive_stall) begin
            if (pending_drive.size() == 0) begin
                report_mismatch($sformatf("unexpected drive beat left=%0d right=%0d kick=%0b",
                                          left_drive, right_drive, kick_active));
            end else begin
                want = pending_drive.pop_front();
                if (left_drive !== want.left)
                    report_mismatch($sformatf("left_drive got %0d want %0d",
                                              left_drive, want.left));
                if (right_drive !== want.right)
                    report_mismatch($sformatf("right_drive got %0d want %0d",
                                              right_drive, want.right));
                if (kick_active !== want.kick)
                    report_mismatch($sformatf("kick_active got %0b want %0b",
                                              kick_active, want.kick));
            end
        end
    end

    // watchdog: too long with no beat moving on either channel
    always @(posedge clk) begin
        if (rst_n) begin
            if ((sample_valid && !sample_stall) || (drive_valid && !drive_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("watchdog: no beat for %0d cycles", quiet_cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial begin
        cfg_mirror = default_config();
        last_pwr   = 0;
        speed_int  = 0;
        dist_term  = 0;
        angle_int  = 0;
        dir_state  = DIR_NONE;
        run_cnt    = 0;
        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_output_backpressure();
        test_random_episodes();

        while (pending_drive.size() != 0) @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (pending_drive.size() != 0)
            report_mismatch($sformatf("%0d drive beats never arrived", pending_drive.size()));
        if (mismatch_cnt == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
